[rtl/core/lsod_pkg.sv]
// Package for the lidar sector obstacle detector: payload structs, configuration
// layout, reset values, state encodings and sizing constants. No dependencies.
package lsod_pkg;

   // Sizing
   localparam int SECTOR_COUNT  = 32;
   localparam int SECTOR_IDX_W  = $clog2(SECTOR_COUNT);
   localparam int SECTOR_CNT_W  = $clog2(SECTOR_COUNT + 1);
   localparam int ANGLE_W       = 14;
   localparam int RANGE_W       = 16;
   localparam int WIDTH_W       = 13;
   localparam int BOUND_W       = 15;
   localparam int WALK_BOUND_W  = WIDTH_W + SECTOR_IDX_W + 2;
   localparam int SUM_W         = 32;
   localparam int COUNT_W       = 12;
   localparam int PROD_W        = RANGE_W + COUNT_W;
   localparam int SECTOR_OUT_W  = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_FLOOR     = 3'd0,
      CSR_RANGE_CEILING   = 3'd1,
      CSR_FIRST_BOUNDARY  = 3'd2,
      CSR_SECTOR_WIDTH    = 3'd3,
      CSR_FRONT_START     = 3'd4,
      CSR_FRONT_END       = 3'd5,
      CSR_SAFE_DISTANCE   = 3'd6
   } csr_index_type;

   // Reset values
   localparam logic [RANGE_W-1:0]        RESET_RANGE_FLOOR    = 16'd100;
   localparam logic [RANGE_W-1:0]        RESET_RANGE_CEILING  = 16'd12000;
   localparam logic signed [ANGLE_W-1:0] RESET_FIRST_BOUNDARY = -14'sd3142;
   localparam logic [WIDTH_W-1:0]        RESET_SECTOR_WIDTH   = 13'd203;
   localparam logic signed [ANGLE_W-1:0] RESET_FRONT_START    = -14'sd524;
   localparam logic signed [ANGLE_W-1:0] RESET_FRONT_END      = 14'sd524;
   localparam logic [RANGE_W-1:0]        RESET_SAFE_DISTANCE  = 16'd500;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] sample_angle_mrad;
      logic [RANGE_W-1:0]        range_mm;
      logic                      scan_last;
   } req_type;

   typedef struct packed {
      logic                    obstacle_ahead;
      logic [SECTOR_OUT_W-1:0] blocked_sector;
   } rsp_type;

   typedef struct packed {
      logic [RANGE_W-1:0]        range_floor_mm;
      logic [RANGE_W-1:0]        range_ceiling_mm;
      logic signed [ANGLE_W-1:0] first_boundary_mrad;
      logic [WIDTH_W-1:0]        sector_width_mrad;
      logic signed [ANGLE_W-1:0] front_start_mrad;
      logic signed [ANGLE_W-1:0] front_end_mrad;
      logic [RANGE_W-1:0]        safe_distance_mm;
   } cfg_type;

   // Classified sample as it travels from front to back
   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic [RANGE_W-1:0]        range;
      logic                      keep;
      logic                      last;
   } item_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_ADVANCE    = 6'b000010,
      ST_UPDATE     = 6'b000100,
      ST_WALK_READ  = 6'b001000,
      ST_WALK_TEST  = 6'b010000,
      ST_REPORT     = 6'b100000
   } back_state_type;

   // Boundary of sector one from the first boundary and the width
   function automatic logic signed [BOUND_W-1:0] first_sector_bound(
      input logic signed [ANGLE_W-1:0] first, input logic [WIDTH_W-1:0] width);
      return $signed({first[ANGLE_W-1], first}) + $signed({2'b00, width});
   endfunction

   function automatic logic signed [WALK_BOUND_W-1:0] walk_ext(
      input logic signed [ANGLE_W-1:0] a);
      return $signed({{(WALK_BOUND_W-ANGLE_W){a[ANGLE_W-1]}}, a});
   endfunction

   localparam logic signed [BOUND_W-1:0] RESET_BOUNDARY =
      first_sector_bound(RESET_FIRST_BOUNDARY, RESET_SECTOR_WIDTH);

endpackage

[rtl/core/lsod_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lsod_front.sv]
// Front end: configuration registers, sample acceptance and range-window
// classification. Depends on lsod_pkg.
module lsod_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lsod_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsod_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_push,
   input  lsod_pkg::req_type                  req_data,
   input  logic                               q_full,
   output logic                               q_push,
   output lsod_pkg::item_type                 q_item,
   output lsod_pkg::cfg_type                  cfg
);
   import lsod_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RANGE_FLOOR:    cfg_in.range_floor_mm      = csr_wdata;
            CSR_RANGE_CEILING:  cfg_in.range_ceiling_mm    = csr_wdata;
            CSR_FIRST_BOUNDARY: cfg_in.first_boundary_mrad = csr_wdata[ANGLE_W-1:0];
            CSR_SECTOR_WIDTH:   cfg_in.sector_width_mrad   = csr_wdata[WIDTH_W-1:0];
            CSR_FRONT_START:    cfg_in.front_start_mrad    = csr_wdata[ANGLE_W-1:0];
            CSR_FRONT_END:      cfg_in.front_end_mrad      = csr_wdata[ANGLE_W-1:0];
            CSR_SAFE_DISTANCE:  cfg_in.safe_distance_mm    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_floor_mm      <= RESET_RANGE_FLOOR;
         cfg_ff.range_ceiling_mm    <= RESET_RANGE_CEILING;
         cfg_ff.first_boundary_mrad <= RESET_FIRST_BOUNDARY;
         cfg_ff.sector_width_mrad   <= RESET_SECTOR_WIDTH;
         cfg_ff.front_start_mrad    <= RESET_FRONT_START;
         cfg_ff.front_end_mrad      <= RESET_FRONT_END;
         cfg_ff.safe_distance_mm    <= RESET_SAFE_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Keep only ranges strictly inside the window
   always_comb begin
      q_push       = req_push && !q_full;
      q_item.angle = req_data.sample_angle_mrad;
      q_item.range = req_data.range_mm;
      q_item.last  = req_data.scan_last;
      q_item.keep  = (req_data.range_mm > cfg_ff.range_floor_mm) &&
                     (req_data.range_mm < cfg_ff.range_ceiling_mm);
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/lsod_queue.sv]
// Short queue of classified samples between front and back.
// Depends on lsod_pkg.
module lsod_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lsod_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output lsod_pkg::item_type head_item
);
   import lsod_pkg::*;

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   always_comb begin
      full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      head_item = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/lsod_back.sv]
// Back end: sector advance, per-sector accumulate, end-of-scan front walk and
// result register. Depends on lsod_pkg and lsod_ram.
module lsod_back (
   input  logic               clock,
   input  logic               reset,
   input  lsod_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  lsod_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lsod_pkg::rsp_type  rsp_data
);
   import lsod_pkg::*;

   back_state_type                  state_ff, state_in;
   item_type                        item_ff, item_in;
   logic [SECTOR_CNT_W-1:0]         cur_ff, cur_in;
   logic signed [BOUND_W-1:0]       bnd_ff, bnd_in;
   logic [SECTOR_IDX_W-1:0]         k_ff, k_in;
   logic signed [WALK_BOUND_W-1:0]  wb_ff, wb_in;
   logic [SECTOR_COUNT-1:0]         valid_ff, valid_in;
   logic                            found_ff, found_in;
   logic [SECTOR_IDX_W-1:0]         hit_ff, hit_in;
   logic                            out_valid_ff, out_valid_in;
   rsp_type                         out_ff, out_in;

   logic                            ram_we;
   logic [SECTOR_IDX_W-1:0]         ram_waddr, ram_raddr;
   entry_type                       ram_wdata, ram_rdata, cur_entry, walk_entry;
   logic [SECTOR_IDX_W-1:0]         cur_idx;
   logic                            in_range;
   logic                            past_bound;
   logic                            in_front;
   logic [PROD_W-1:0]               limit;
   logic                            trip;
   logic                            take;

   lsod_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SECTOR_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      cur_idx    = cur_ff[SECTOR_IDX_W-1:0];
      in_range   = (cur_ff < SECTOR_CNT_W'(SECTOR_COUNT));
      past_bound = $signed({item_ff.angle[ANGLE_W-1], item_ff.angle}) > bnd_ff;
      // An entry never written this scan reads as zero
      cur_entry  = valid_ff[cur_idx] ? ram_rdata : '0;
      walk_entry = valid_ff[k_ff] ? ram_rdata : '0;
      in_front   = (wb_ff >= walk_ext(cfg.front_start_mrad)) &&
                   (wb_ff <= walk_ext(cfg.front_end_mrad));
      limit      = cfg.safe_distance_mm * walk_entry.count;
      trip       = in_front && (walk_entry.count != '0) &&
                   (walk_entry.sum < SUM_W'(limit));
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      bnd_in       = bnd_ff;
      k_in         = k_ff;
      wb_in        = wb_ff;
      valid_in     = valid_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cur_idx;
      ram_wdata    = cur_entry;
      ram_raddr    = cur_idx;
      take         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            take = 1'b1;
         end
         ST_ADVANCE: begin
            // Step one boundary per cycle until the sample fits or no sector is left
            if (in_range && past_bound) begin
               cur_in = cur_ff + 1'b1;
               bnd_in = bnd_ff + $signed({2'b00, cfg.sector_width_mrad});
            end else if (in_range) begin
               state_in = ST_UPDATE;
            end else if (item_ff.last) begin
               state_in = ST_WALK_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (cur_entry.count < COUNT_MAX) begin
               ram_we          = 1'b1;
               ram_wdata.sum   = cur_entry.sum + SUM_W'(item_ff.range);
               ram_wdata.count = cur_entry.count + 1'b1;
               valid_in[cur_idx] = 1'b1;
            end
            if (item_ff.last) begin
               state_in = ST_WALK_READ;
            end else begin
               take = 1'b1;
            end
         end
         ST_WALK_READ: begin
            ram_raddr = k_ff;
            state_in  = ST_WALK_TEST;
         end
         ST_WALK_TEST: begin
            ram_raddr = k_ff;
            if (trip) begin
               found_in = 1'b1;
               hit_in   = k_ff;
               state_in = ST_REPORT;
            end else if (k_ff == SECTOR_IDX_W'(SECTOR_COUNT - 1)) begin
               state_in = ST_REPORT;
            end else begin
               k_in     = k_ff + 1'b1;
               wb_in    = wb_ff + $signed({{(WALK_BOUND_W-WIDTH_W){1'b0}},
                                           cfg.sector_width_mrad});
               state_in = ST_WALK_READ;
            end
         end
         ST_REPORT: begin
            // Hold until the result register frees, then clear the scan
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in          = 1'b1;
               out_in.obstacle_ahead = found_ff;
               out_in.blocked_sector = SECTOR_OUT_W'(hit_ff);
               valid_in              = '0;
               cur_in                = SECTOR_CNT_W'(1);
               bnd_in = first_sector_bound(cfg.first_boundary_mrad,
                                           cfg.sector_width_mrad);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take the next sample and route it by its class
      if (take) begin
         state_in = ST_IDLE;
         if (!q_empty) begin
            q_pop   = 1'b1;
            item_in = q_item;
            if (q_item.keep) begin
               state_in = ST_ADVANCE;
            end else if (q_item.last) begin
               state_in = ST_WALK_READ;
            end
         end
      end

      // Prime the walk on entry
      if (state_in == ST_WALK_READ && state_ff != ST_WALK_TEST) begin
         k_in     = SECTOR_IDX_W'(1);
         wb_in    = walk_ext(cfg.first_boundary_mrad) +
                    $signed({{(WALK_BOUND_W-WIDTH_W){1'b0}}, cfg.sector_width_mrad});
         found_in = 1'b0;
         hit_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= SECTOR_CNT_W'(1);
         bnd_ff       <= RESET_BOUNDARY;
         valid_ff     <= '0;
         found_ff     <= 1'b0;
         hit_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         bnd_ff       <= bnd_in;
         valid_ff     <= valid_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      k_ff    <= k_in;
      wb_ff   <= wb_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/core/lidar_sector_obstacle_detector_top.sv]
// Lidar sector obstacle detector, top level. Depends on lsod_pkg, lsod_front,
// lsod_queue and lsod_back (which holds the sector store RAM).
// A kept sample steps the sector boundary until it fits, then updates its sector's entry;
// a dropped one is only popped. The last sample of a scan adds a front walk that tests
// each sector in turn from sector one, stopping at the first that trips, then a report.
// Reset (synchronous, active high) loads register defaults and empties all stores.
module lidar_sector_obstacle_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_push,
   output logic                               req_full,
   input  lsod_pkg::req_type                  req_data,
   // result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output lsod_pkg::rsp_type                  rsp_data,
   // register write port
   input  logic                               csr_we,
   input  logic [lsod_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsod_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsod_pkg::*;

   cfg_type  cfg;
   logic     q_push, q_full, q_pop, q_empty;
   item_type q_in_item, q_head_item;

   // Front: accept each sample transaction while the queue has room and tag it keep or drop
   lsod_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item),
      .cfg       (cfg)
   );

   // Decouple: the front keeps taking samples while the back walks sectors, until the queue fills
   lsod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // Back: bin, accumulate, and evaluate front sectors at end of scan
   lsod_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Stall the sample side while the queue is full
   assign req_full = q_full;

endmodule
